### src/smps_pkg.sv
// Package: word types, register map, microprogram and phase tables of the microstep sequencer.
`default_nettype none
package smps_pkg;

	// input word
	typedef struct packed {
		logic [1:0]         func;
		logic signed [7:0]  direct_step;
		logic signed [15:0] planned_speed;
		logic [31:0]        now_time;
	} cmd_word_t;

	// result word
	typedef struct packed {
		logic        pwm_valid;
		logic        stepped;
		logic        direct_step_bad;
		logic [1:0]  chan_a;
		logic [1:0]  chan_b;
		logic [15:0] duty_a;
		logic [15:0] duty_b;
		logic [3:0]  position;
	} res_word_t;

	// drive modes
	localparam logic [1:0] FUNC_IDLE   = 2'd0;
	localparam logic [1:0] FUNC_DIRECT = 2'd1;
	localparam logic [1:0] FUNC_KEEP   = 2'd2;
	localparam logic [1:0] FUNC_MOVE   = 2'd3;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_STEP_SCALE = 3'd0;
	localparam logic [2:0] REG_TICKS      = 3'd1;
	localparam logic [2:0] REG_PERIOD     = 3'd2;
	localparam logic [2:0] REG_KEEP_DUTY  = 3'd3;
	localparam logic [2:0] REG_FULL_DUTY  = 3'd4;

	localparam int ADDR_BITS = 5;
	localparam int DIV_STEPS = 32;

	// step scale codes
	localparam logic [3:0] SCALE_HALF    = 4'd2;
	localparam logic [3:0] SCALE_QUARTER = 4'd4;

	// datapath operations
	localparam logic [2:0] OP_NONE     = 3'd0;
	localparam logic [2:0] OP_LATCH    = 3'd1;
	localparam logic [2:0] OP_DIV_INIT = 3'd2;
	localparam logic [2:0] OP_DIV_STEP = 3'd3;
	localparam logic [2:0] OP_STEP     = 3'd4;
	localparam logic [2:0] OP_PWM      = 3'd5;
	localparam logic [2:0] OP_BAD      = 3'd6;
	localparam logic [2:0] OP_EMIT     = 3'd7;

	// jump conditions
	localparam logic [3:0] C_NEVER       = 4'd0;
	localparam logic [3:0] C_ALWAYS      = 4'd1;
	localparam logic [3:0] C_NO_WORD     = 4'd2;
	localparam logic [3:0] C_FUNC_IDLE   = 4'd3;
	localparam logic [3:0] C_FUNC_DIRECT = 4'd4;
	localparam logic [3:0] C_SPEED_ZERO  = 4'd5;
	localparam logic [3:0] C_DIV_BUSY    = 4'd6;
	localparam logic [3:0] C_NOT_DUE     = 4'd7;
	localparam logic [3:0] C_NOT_UNIT    = 4'd8;
	localparam logic [3:0] C_OUT_BUSY    = 4'd9;

	// program addresses
	localparam logic [3:0] PC_WAIT   = 4'd0;
	localparam logic [3:0] PC_DIV    = 4'd5;
	localparam logic [3:0] PC_PWM    = 4'd8;
	localparam logic [3:0] PC_EMIT   = 4'd9;
	localparam logic [3:0] PC_DIRECT = 4'd11;
	localparam logic [3:0] PC_BAD    = 4'd13;
	localparam logic [3:0] PC_LAST   = 4'd13;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] cond;
		logic [3:0] target;
	} ctrl_t;

	// control store: one control word per step
	function automatic ctrl_t prog_rom(input logic [3:0] pc);
		ctrl_t w;
		case (pc)
			4'd0:    w = '{OP_LATCH,    C_NO_WORD,     PC_WAIT};
			4'd1:    w = '{OP_NONE,     C_FUNC_IDLE,   PC_EMIT};
			4'd2:    w = '{OP_NONE,     C_FUNC_DIRECT, PC_DIRECT};
			4'd3:    w = '{OP_NONE,     C_SPEED_ZERO,  PC_PWM};
			4'd4:    w = '{OP_DIV_INIT, C_NEVER,       PC_WAIT};
			4'd5:    w = '{OP_DIV_STEP, C_DIV_BUSY,    PC_DIV};
			4'd6:    w = '{OP_NONE,     C_NOT_DUE,     PC_PWM};
			4'd7:    w = '{OP_STEP,     C_NEVER,       PC_WAIT};
			4'd8:    w = '{OP_PWM,      C_NEVER,       PC_WAIT};
			4'd9:    w = '{OP_EMIT,     C_OUT_BUSY,    PC_EMIT};
			4'd10:   w = '{OP_NONE,     C_ALWAYS,      PC_WAIT};
			4'd11:   w = '{OP_NONE,     C_NOT_UNIT,    PC_BAD};
			4'd12:   w = '{OP_STEP,     C_ALWAYS,      PC_PWM};
			4'd13:   w = '{OP_BAD,      C_ALWAYS,      PC_EMIT};
			default: w = '{OP_NONE,     C_ALWAYS,      PC_WAIT};
		endcase
		return w;
	endfunction

	// phase channel pattern per full step
	function automatic logic [1:0] chan_first(input logic [1:0] f);
		logic [1:0] c;
		case (f)
			2'd0:    c = 2'd0;
			2'd1:    c = 2'd2;
			2'd2:    c = 2'd1;
			default: c = 2'd3;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] chan_second(input logic [1:0] f);
		logic [1:0] c;
		case (f)
			2'd0:    c = 2'd2;
			2'd1:    c = 2'd1;
			2'd2:    c = 2'd3;
			default: c = 2'd0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

### src/stepper_microstep_pwm_sequencer_core.sv
// Top level: microcoded two-phase stepper microstep sequencer with APB register port.
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+------------------------------------
//  cmd     | in        | cmd_valid/cmd_stall | func, direct_step, speed, now_time
//  res     | out       | res_valid/res_stall | pwm flags, channels, duties, position
//  apb     | in/out    | psel/penable/pready | five config registers at 4*i
//
// A move or keep word with nonzero speed runs the 32-step restoring divide of
// ticks_per_second by |speed|; zero-speed, idle and direct words skip it.
// The word is taken only at the wait step.
// The result waits in an output register; a stalled result holds the program at
// its emit step. Reset returns the registers to their defaults and clears the
// position and step start time.
`default_nettype none
module stepper_microstep_pwm_sequencer_core #(
	parameter int TIME_BITS = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cmd_valid,
	output logic                             cmd_stall,
	input  wire  smps_pkg::cmd_word_t        cmd,
	output logic                             res_valid,
	input  wire                              res_stall,
	output smps_pkg::res_word_t              res,
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [smps_pkg::ADDR_BITS-1:0]   paddr,
	input  wire  [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int WIDE = (TIME_BITS > 32) ? TIME_BITS : 32;

	// configuration registers
	logic [3:0]  scale_q;
	logic [31:0] tps_q;
	logic [15:0] period_q;
	logic [15:0] keep_q;
	logic [15:0] full_q;

	// sequencer and datapath state
	logic [3:0]           pc_q;
	logic [3:0]           pos_q;
	logic [TIME_BITS-1:0] start_q;
	logic [TIME_BITS-1:0] now_q;
	logic [1:0]           func_q;
	logic [7:0]           ds_q;
	logic                 neg_q;
	logic [15:0]          mag_q;
	logic [15:0]          rem_q;
	logic [31:0]          quo_q;
	logic [4:0]           cnt_q;
	smps_pkg::res_word_t  wrk_q;
	smps_pkg::res_word_t  res_q;
	logic                 res_valid_q;

	smps_pkg::ctrl_t      cw;
	logic                 cond_hit;
	logic                 out_busy;
	logic                 cfg_wr;
	logic [WIDE-1:0]      now_wide;
	logic [TIME_BITS-1:0] elapsed;
	logic                 not_due;
	logic                 ds_unit;
	logic [16:0]          trial;
	logic [3:0]           amount;
	logic                 forward;
	logic [3:0]           next_pos;
	logic                 keep_mode;
	logic [15:0]          base;
	logic [17:0]          prod_a;
	logic [17:0]          prod_b;
	logic [15:0]          da;
	logic [15:0]          db;
	smps_pkg::res_word_t  emit_w;

	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite & pready;
	assign cmd_stall = (pc_q != smps_pkg::PC_WAIT);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign out_busy  = res_valid_q & res_stall;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= 4'd1;
			tps_q    <= 32'd1000;
			period_q <= 16'd255;
			keep_q   <= 16'd64;
			full_q   <= 16'd255;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				smps_pkg::REG_STEP_SCALE: scale_q  <= pwdata[3:0];
				smps_pkg::REG_TICKS:      tps_q    <= pwdata;
				smps_pkg::REG_PERIOD:     period_q <= pwdata[15:0];
				smps_pkg::REG_KEEP_DUTY:  keep_q   <= pwdata[15:0];
				smps_pkg::REG_FULL_DUTY:  full_q   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[4:2])
			smps_pkg::REG_STEP_SCALE: prdata = {28'd0, scale_q};
			smps_pkg::REG_TICKS:      prdata = tps_q;
			smps_pkg::REG_PERIOD:     prdata = {16'd0, period_q};
			smps_pkg::REG_KEEP_DUTY:  prdata = {16'd0, keep_q};
			smps_pkg::REG_FULL_DUTY:  prdata = {16'd0, full_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// datapath terms
	assign now_wide = WIDE'(cmd.now_time);
	assign elapsed  = now_q - start_q;
	assign not_due  = WIDE'(elapsed) < WIDE'(quo_q);
	assign ds_unit  = (ds_q == 8'h01) || (ds_q == 8'hFF);
	assign trial    = {rem_q, quo_q[31]} - {1'b0, mag_q};

	always_comb begin
		case (scale_q)
			smps_pkg::SCALE_HALF:    amount = 4'd2;
			smps_pkg::SCALE_QUARTER: amount = 4'd1;
			default:                 amount = 4'd4;
		endcase
	end

	assign forward  = (func_q == smps_pkg::FUNC_DIRECT) ? (ds_q == 8'h01) : !neg_q;
	assign next_pos = forward ? (pos_q + amount) : (pos_q - amount);

	// duties weighted by substep
	assign keep_mode = (func_q == smps_pkg::FUNC_KEEP);
	assign base      = keep_mode ? keep_q : full_q;
	assign prod_a    = 18'(base) * 18'(3'd4 - {1'b0, pos_q[1:0]});
	assign prod_b    = 18'(base) * 18'(pos_q[1:0]);
	assign da = (!keep_mode && (prod_a[17:2] > period_q)) ? period_q : prod_a[17:2];
	assign db = (!keep_mode && (prod_b[17:2] > period_q)) ? period_q : prod_b[17:2];

	// result word with the current position
	always_comb begin
		emit_w          = wrk_q;
		emit_w.position = pos_q;
	end

	// control word and jump condition
	assign cw = smps_pkg::prog_rom(pc_q);

	always_comb begin
		case (cw.cond)
			smps_pkg::C_NEVER:       cond_hit = 1'b0;
			smps_pkg::C_ALWAYS:      cond_hit = 1'b1;
			smps_pkg::C_NO_WORD:     cond_hit = !cmd_valid;
			smps_pkg::C_FUNC_IDLE:   cond_hit = (func_q == smps_pkg::FUNC_IDLE);
			smps_pkg::C_FUNC_DIRECT: cond_hit = (func_q == smps_pkg::FUNC_DIRECT);
			smps_pkg::C_SPEED_ZERO:  cond_hit = (mag_q == 16'd0);
			smps_pkg::C_DIV_BUSY:    cond_hit = (cnt_q != 5'(smps_pkg::DIV_STEPS - 1));
			smps_pkg::C_NOT_DUE:     cond_hit = not_due;
			smps_pkg::C_NOT_UNIT:    cond_hit = !ds_unit;
			smps_pkg::C_OUT_BUSY:    cond_hit = out_busy;
			default:                 cond_hit = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= smps_pkg::PC_WAIT;
		end else if (cond_hit) begin
			pc_q <= cw.target;
		end else begin
			pc_q <= pc_q + 4'd1;
		end
	end

	// position and step start time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= 4'd0;
			start_q <= '0;
		end else if (cw.op == smps_pkg::OP_STEP) begin
			pos_q   <= next_pos;
			start_q <= now_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cw.op == smps_pkg::OP_EMIT && !out_busy) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (cw.op)
			smps_pkg::OP_LATCH: begin
				if (cmd_valid) begin
					func_q <= cmd.func;
					ds_q   <= cmd.direct_step;
					neg_q  <= cmd.planned_speed[15];
					mag_q  <= cmd.planned_speed[15] ? (16'd0 - cmd.planned_speed)
					                                : cmd.planned_speed;
					now_q  <= now_wide[TIME_BITS-1:0];
					wrk_q  <= '0;
				end
			end
			smps_pkg::OP_DIV_INIT: begin
				rem_q <= 16'd0;
				quo_q <= tps_q;
				cnt_q <= 5'd0;
			end
			smps_pkg::OP_DIV_STEP: begin
				// remainder stays below the divisor, so its top bit is always clear
				rem_q <= trial[16] ? {rem_q[14:0], quo_q[31]} : trial[15:0];
				quo_q <= {quo_q[30:0], !trial[16]};
				cnt_q <= cnt_q + 5'd1;
			end
			smps_pkg::OP_STEP: begin
				wrk_q.stepped <= 1'b1;
			end
			smps_pkg::OP_PWM: begin
				wrk_q.pwm_valid <= 1'b1;
				wrk_q.chan_a    <= smps_pkg::chan_first(pos_q[3:2]);
				wrk_q.chan_b    <= smps_pkg::chan_second(pos_q[3:2]);
				wrk_q.duty_a    <= da;
				wrk_q.duty_b    <= db;
			end
			smps_pkg::OP_BAD: begin
				wrk_q.direct_step_bad <= (ds_q != 8'd0);
			end
			smps_pkg::OP_EMIT: begin
				if (!out_busy) begin
					res_q <= emit_w;
				end
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// a result appears only from the emit step
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(pc_q == smps_pkg::PC_EMIT))
		else $error("result raised outside the emit step");

	// a step always comes with a PWM refresh
	a_step_refresh: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.stepped) |-> res.pwm_valid)
		else $error("step reported without PWM refresh");

	// a rejected direct step refreshes nothing
	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.direct_step_bad) |-> (!res.pwm_valid && !res.stepped))
		else $error("bad direct step changed the drive");

	// the program counter stays inside the control store
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q <= smps_pkg::PC_LAST)
		else $error("step counter left the program");
`endif

endmodule
`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the stepper microstep sequencer: command words, APB, result checks.
`timescale 1ns / 1ps
module tb;

	// receiver stall patterns
	localparam int STALL_NONE   = 0;
	localparam int STALL_COIN   = 1;
	localparam int STALL_HEAVY  = 2;
	localparam int STALL_BLOCKS = 3;

	// phase channel pairs per full step, two bits per entry
	localparam logic [7:0] PHASE_A = {2'd3, 2'd1, 2'd2, 2'd0};
	localparam logic [7:0] PHASE_B = {2'd0, 2'd3, 2'd1, 2'd2};

	// step scale settings swept by the scale test
	localparam logic [19:0] SCALE_SET = {4'd3, 4'd15, 4'd0, smps_pkg::SCALE_QUARTER,
		smps_pkg::SCALE_HALF};

	// duty limit rows: period, keep duty, full duty, ticks per second
	localparam logic [63:0]  LIM_PERIOD = {16'd100, 16'd65535, 16'd1, 16'd0};
	localparam logic [63:0]  LIM_KEEP   = {16'd1, 16'd65535, 16'd0, 16'd65535};
	localparam logic [63:0]  LIM_FULL   = {16'd65535, 16'd65535, 16'd0, 16'd65535};
	localparam logic [127:0] LIM_TICKS  = {32'd7, 32'd1000, 32'hFFFF_FFFF, 32'd1};

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cmd_valid = 1'b0;
	logic                           cmd_stall;
	smps_pkg::cmd_word_t            cmd       = '0;
	logic                           res_valid;
	logic                           res_stall = 1'b0;
	smps_pkg::res_word_t            res;
	logic                           psel      = 1'b0;
	logic                           penable   = 1'b0;
	logic                           pwrite    = 1'b0;
	logic [smps_pkg::ADDR_BITS-1:0] paddr     = '0;
	logic [31:0]                    pwdata    = '0;
	logic [31:0]                    prdata;
	logic                           pready;

	// register copies and sequencer state as the block should hold them
	logic [3:0]  cfg_scale  = 4'd1;
	logic [31:0] cfg_ticks  = 32'd1000;
	logic [15:0] cfg_period = 16'd255;
	logic [15:0] cfg_keep   = 16'd64;
	logic [15:0] cfg_full   = 16'd255;
	logic [3:0]  seq_pos    = 4'd0;
	logic [31:0] seq_t0     = 32'd0;

	smps_pkg::res_word_t res_due[$];
	int          err_count  = 0;
	int          burst_left = 0;
	logic [31:0] clock_now  = 32'd0;
	int          stall_mode = STALL_NONE;
	int          stall_left = 0;

	stepper_microstep_pwm_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

	// ---------------------------------------------------------------- prediction

	// one step of the index; the step size follows the scale setting
	function automatic void take_step(input logic fwd, input logic [31:0] now);
		logic [3:0] amount;
		amount = (cfg_scale == smps_pkg::SCALE_HALF) ? 4'd2 :
			(cfg_scale == smps_pkg::SCALE_QUARTER) ? 4'd1 : 4'd4;
		seq_pos = fwd ? seq_pos + amount : seq_pos - amount;
		seq_t0 = now;
	endfunction

	// channel pair and substep-weighted duties for the present index
	function automatic void fill_duties(inout smps_pkg::res_word_t r, input logic keep);
		int unsigned base, da, db, sub;
		sub = seq_pos[1:0];
		base = keep ? cfg_keep : cfg_full;
		da = base * (4 - sub) / 4;
		db = base * sub / 4;
		if (!keep) begin
			if (da > cfg_period) da = cfg_period;
			if (db > cfg_period) db = cfg_period;
		end
		r.pwm_valid = 1'b1;
		r.chan_a = PHASE_A[2*seq_pos[3:2] +: 2];
		r.chan_b = PHASE_B[2*seq_pos[3:2] +: 2];
		r.duty_a = da[15:0];
		r.duty_b = db[15:0];
	endfunction

	// expected result of one command word; moves the state on
	function automatic smps_pkg::res_word_t advance_sequencer(input smps_pkg::cmd_word_t w);
		smps_pkg::res_word_t r;
		logic [16:0] mag;
		logic [31:0] ivl, elapsed;
		r = '0;
		case (w.func)
			smps_pkg::FUNC_DIRECT: begin
				if (w.direct_step == 8'sd1 || w.direct_step == -8'sd1) begin
					take_step(w.direct_step == 8'sd1, w.now_time);
					r.stepped = 1'b1;
					fill_duties(r, 1'b0);
				end else if (w.direct_step != 8'sd0) begin
					r.direct_step_bad = 1'b1;
				end
			end
			smps_pkg::FUNC_KEEP, smps_pkg::FUNC_MOVE: begin
				if (w.planned_speed != 16'sd0) begin
					// -32768 gives a magnitude of 32768
					mag = w.planned_speed[15] ? 17'h10000 - {1'b0, w.planned_speed}
						: {1'b0, w.planned_speed};
					ivl = cfg_ticks / mag;
					elapsed = w.now_time - seq_t0;
					if (elapsed >= ivl) begin
						take_step(!w.planned_speed[15], w.now_time);
						r.stepped = 1'b1;
					end
				end
				fill_duties(r, w.func == smps_pkg::FUNC_KEEP);
			end
			default: ;
		endcase
		r.position = seq_pos;
		return r;
	endfunction

	function automatic logic [31:0] reg_value(input logic [2:0] idx);
		case (idx)
			smps_pkg::REG_STEP_SCALE: return {28'd0, cfg_scale};
			smps_pkg::REG_TICKS:      return cfg_ticks;
			smps_pkg::REG_PERIOD:     return {16'd0, cfg_period};
			smps_pkg::REG_KEEP_DUTY:  return {16'd0, cfg_keep};
			default:                  return {16'd0, cfg_full};
		endcase
	endfunction

	function automatic logic [31:0] reg_mask(input logic [2:0] idx);
		case (idx)
			smps_pkg::REG_STEP_SCALE: return 32'h0000_000F;
			smps_pkg::REG_TICKS:      return 32'hFFFF_FFFF;
			default:                  return 32'h0000_FFFF;
		endcase
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			err_count++;
		end
	endtask

	// each accepted result word against the oldest expectation
	always @(posedge clk) begin : res_check
		smps_pkg::res_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (res_due.size() == 0) begin
				$error("result word with nothing expected");
				err_count++;
			end else begin
				want = res_due.pop_front();
				check_field("pwm_valid", want.pwm_valid, res.pwm_valid);
				check_field("stepped", want.stepped, res.stepped);
				check_field("direct_step_bad", want.direct_step_bad, res.direct_step_bad);
				check_field("chan_a", want.chan_a, res.chan_a);
				check_field("chan_b", want.chan_b, res.chan_b);
				check_field("duty_a", want.duty_a, res.duty_a);
				check_field("duty_b", want.duty_b, res.duty_b);
				check_field("position", want.position, res.position);
			end
		end
	end

	// receiver stall, switching to a random pattern at random intervals
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(STALL_NONE, STALL_BLOCKS);
			stall_left = $urandom_range(16, 400);
		end else begin
			stall_left--;
		end
		case (stall_mode)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_COIN:  res_stall <= ($urandom_range(0, 1) == 1);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 7) != 0);
			default:     res_stall <= ((stall_left % 32) >= 20);
		endcase
	end

	// ---------------------------------------------------------------- drivers

	// one command word; bursts end in a random gap with valid low
	task automatic send_word(input smps_pkg::cmd_word_t w);
		cmd <= w;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall);
		res_due.push_back(advance_sequencer(w));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12)) @(posedge clk);
			burst_left = $urandom_range(0, 30);
		end
	endtask

	// hold off until every expected result has come, then let the block go idle
	task automatic settle();
		if (cmd_valid) cmd_valid <= 1'b0;
		burst_left = 0;
		while (res_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// APB transfer: setup, access, done when pready is seen high
	task automatic apb_access(input logic wr, input logic [2:0] idx, input logic [31:0] wdata,
			output logic [31:0] rdata);
		logic done;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		done = 1'b0;
		while (!done) begin
			@(negedge clk);
			rdata = prdata;
			done = pready;
			@(posedge clk);
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// register write once idle, then read back
	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		settle();
		apb_access(1'b1, idx, value, rd);
		case (idx)
			smps_pkg::REG_STEP_SCALE: cfg_scale = value[3:0];
			smps_pkg::REG_TICKS:      cfg_ticks = value;
			smps_pkg::REG_PERIOD:     cfg_period = value[15:0];
			smps_pkg::REG_KEEP_DUTY:  cfg_keep = value[15:0];
			default:                  cfg_full = value[15:0];
		endcase
		apb_access(1'b0, idx, 32'd0, rd);
		check_field("register readback", reg_value(idx), rd & reg_mask(idx));
	endtask

	function automatic smps_pkg::cmd_word_t word_of(input logic [1:0] f,
			input logic signed [7:0] ds, input logic signed [15:0] sp, input logic [31:0] t);
		smps_pkg::cmd_word_t w;
		w.func = f;
		w.direct_step = ds;
		w.planned_speed = sp;
		w.now_time = t;
		return w;
	endfunction

	// mostly well-formed traffic: time moves on by about one step interval
	function automatic smps_pkg::cmd_word_t random_word();
		smps_pkg::cmd_word_t w;
		int unsigned pick;
		logic [16:0] mag;
		logic [63:0] span;
		w.direct_step = $urandom;
		w.planned_speed = $urandom;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			w.func = smps_pkg::FUNC_IDLE;
		end else if (pick < 25) begin
			w.func = smps_pkg::FUNC_DIRECT;
			if ($urandom_range(0, 4) != 0)
				w.direct_step = $urandom_range(0, 1) ? 8'sd1 : -8'sd1;
		end else begin
			w.func = $urandom_range(0, 1) ? smps_pkg::FUNC_KEEP : smps_pkg::FUNC_MOVE;
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				w.planned_speed = 16'sd0;
			end else if (pick > 1) begin
				w.planned_speed = $urandom_range(1, 2000);
				if ($urandom_range(0, 1)) w.planned_speed = -w.planned_speed;
			end
		end
		mag = w.planned_speed[15] ? 17'h10000 - {1'b0, w.planned_speed} : {1'b0, w.planned_speed};
		span = (mag == 17'd0) ? 64'd50 : 2 * (cfg_ticks / mag) + 2;
		if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
		if ($urandom_range(0, 19) == 0) clock_now = $urandom;
		else clock_now = clock_now + $urandom_range(0, span[31:0]);
		w.now_time = clock_now;
		return w;
	endfunction

	// ---------------------------------------------------------------- tests

	task automatic test_register_defaults();
		logic [31:0] rd;
		for (int i = smps_pkg::REG_STEP_SCALE; i <= smps_pkg::REG_FULL_DUTY; i++) begin
			apb_access(1'b0, i[2:0], 32'd0, rd);
			check_field("register after reset", reg_value(i[2:0]), rd & reg_mask(i[2:0]));
		end
	endtask

	// field extremes, every mode, bad steps, boundaries and wraps at reset settings
	task automatic test_directed();
		send_word(word_of(smps_pkg::FUNC_IDLE, 8'sh7F, 16'sh7FFF, 32'hFFFF_FFFF));
		send_word(word_of(smps_pkg::FUNC_DIRECT, -8'sd1, 16'sd0, 32'd5));   // wraps below zero
		send_word(word_of(smps_pkg::FUNC_DIRECT, 8'sd1, -16'sd1, 32'd6));   // wraps back up
		send_word(word_of(smps_pkg::FUNC_DIRECT, 8'sd0, 16'sd9, 32'd7));
		send_word(word_of(smps_pkg::FUNC_DIRECT, 8'sd2, 16'sd9, 32'd8));
		send_word(word_of(smps_pkg::FUNC_DIRECT, -8'sd128, 16'sd0, 32'd9));
		send_word(word_of(smps_pkg::FUNC_DIRECT, 8'sd127, 16'sd0, 32'd10));
		send_word(word_of(smps_pkg::FUNC_KEEP, 8'sd0, 16'sd0, 32'd11));
		send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd1, 16'sd0, 32'd12));
		send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, 16'sd32767, 32'd100));
		send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, -16'sd32768, 32'd200));
		send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, 16'sd1, 32'd500));    // not yet due
		send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, 16'sd1, 32'd1200));   // due exactly
		send_word(word_of(smps_pkg::FUNC_KEEP, 8'sd0, -16'sd1, 32'd2199));  // one tick short
		send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, 16'sd1, 32'hFFFF_FFF0));
		send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, 16'sd1, 32'd100));    // across the wrap
		send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, 16'sd1, 32'd1000));
		send_word(word_of(smps_pkg::FUNC_KEEP, -8'sd1, 16'sd2, 32'h7FFF_FFFF));
		send_word(word_of(smps_pkg::FUNC_IDLE, 8'sd0, 16'sd0, 32'd0));
	endtask

	// half, quarter and full step sizes, forward and back through the wrap
	task automatic test_step_scales();
		logic signed [15:0] sp;
		for (int i = 0; i < 5; i++) begin
			cfg_write(smps_pkg::REG_STEP_SCALE, {28'd0, SCALE_SET[4*i +: 4]});
			for (int j = 0; j < 12; j++) begin
				clock_now = clock_now + 32'd3;
				if ($urandom_range(0, 1)) begin
					send_word(word_of(smps_pkg::FUNC_DIRECT,
						($urandom_range(0, 3) != 0) ? 8'sd1 : -8'sd1, 16'sd0, clock_now));
				end else begin
					sp = $urandom_range(0, 1) ? 16'sd500 : -16'sd500;
					send_word(word_of($urandom_range(0, 1) ? smps_pkg::FUNC_KEEP
						: smps_pkg::FUNC_MOVE, 8'sd0, sp, clock_now));
				end
			end
		end
	endtask

	// zero and largest period and duties, smallest and largest tick rates, at quarter steps
	task automatic test_duty_limits();
		for (int i = 0; i < 4; i++) begin
			cfg_write(smps_pkg::REG_PERIOD, {16'd0, LIM_PERIOD[16*i +: 16]});
			cfg_write(smps_pkg::REG_KEEP_DUTY, {16'd0, LIM_KEEP[16*i +: 16]});
			cfg_write(smps_pkg::REG_FULL_DUTY, {16'd0, LIM_FULL[16*i +: 16]});
			cfg_write(smps_pkg::REG_TICKS, LIM_TICKS[32*i +: 32]);
			cfg_write(smps_pkg::REG_STEP_SCALE, {28'd0, smps_pkg::SCALE_QUARTER});
			for (int j = 0; j < 10; j++) begin
				case (j % 4)
					0: send_word(word_of(smps_pkg::FUNC_DIRECT, 8'sd1, 16'sd0, clock_now));
					1: send_word(word_of(smps_pkg::FUNC_KEEP, 8'sd0, 16'sd0, clock_now));
					2: send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, 16'sd0, clock_now));
					default: send_word(word_of(smps_pkg::FUNC_MOVE, 8'sd0, 16'sd1,
						seq_t0 - 32'd1));
				endcase
			end
		end
	endtask

	// random settings per phase, random traffic in between
	task automatic test_random_traffic();
		int unsigned pick;
		for (int ph = 0; ph < 8; ph++) begin
			pick = $urandom_range(0, 2);
			if (pick == 0) cfg_write(smps_pkg::REG_STEP_SCALE, $urandom_range(0, 15));
			else if (pick == 1) cfg_write(smps_pkg::REG_STEP_SCALE, {28'd0, smps_pkg::SCALE_HALF});
			else cfg_write(smps_pkg::REG_STEP_SCALE, {28'd0, smps_pkg::SCALE_QUARTER});
			pick = $urandom_range(0, 9);
			if (pick < 7) cfg_write(smps_pkg::REG_TICKS, $urandom_range(1, 5000));
			else if (pick < 9) cfg_write(smps_pkg::REG_TICKS, $urandom_range(1, 200));
			else cfg_write(smps_pkg::REG_TICKS, $urandom | 32'd1);
			cfg_write(smps_pkg::REG_FULL_DUTY, $urandom_range(0, 65535));
			cfg_write(smps_pkg::REG_PERIOD, $urandom_range(0, 65535));
			cfg_write(smps_pkg::REG_KEEP_DUTY, $urandom_range(0, 65535));
			repeat (123) send_word(random_word());
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_defaults();
		test_directed();
		test_step_scales();
		test_duty_limits();
		test_random_traffic();
		settle();
		repeat (50) @(posedge clk);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
